>>> rtl/core/pdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdd_pkg;

   // Fixed field widths
   localparam int YEAR_W  = 7;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int RUN_W   = 7;
   localparam int CODE_W  = 20;
   localparam int SLOT_W  = 6;

   localparam int MAX_RUN_DEF = 64;

   // Calendar constants
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_TOP  = 7'd99;
   localparam logic [YEAR_W-1:0]  YEAR_SPAN = 7'd100;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } pdd_state_type;

   typedef struct packed {
      logic load;   // capture a new request
      logic step;   // emit current date, move back one day
   } pdd_cmd_type;

   typedef struct packed {
      logic len_zero;   // request on the ports asks for no dates
      logic slot_zero;  // current date is the last of the run
   } pdd_sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] year,
                                                  input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      len = 5'd31;
      if (month == MONTH_FEB) begin
         len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = 5'd30;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/pdd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pdd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  pdd_pkg::pdd_sts_type      sts,
   output pdd_pkg::pdd_cmd_type      cmd,
   output logic                      busy,
   output logic                      strobe
);
   import pdd_pkg::*;

   pdd_state_type state_ff, state_in;
   logic          strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.step;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (!sts.len_zero) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.slot_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = strobe_ff;

endmodule

`default_nettype wire

>>> rtl/core/pdd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module pdd_dpath #(
   parameter int MAX_RUN = pdd_pkg::MAX_RUN_DEF
) (
   input  wire logic                         clock,
   input  pdd_pkg::pdd_cmd_type              cmd,
   output pdd_pkg::pdd_sts_type              sts,
   input  wire logic [pdd_pkg::YEAR_W-1:0]   req_start_year,
   input  wire logic [pdd_pkg::MONTH_W-1:0]  req_start_month,
   input  wire logic [pdd_pkg::DAY_W-1:0]    req_start_day,
   input  wire logic [pdd_pkg::RUN_W-1:0]    req_run_length,
   output logic      [pdd_pkg::CODE_W-1:0]   rsp_date_code,
   output logic      [pdd_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic      [pdd_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic      [pdd_pkg::DAY_W-1:0]    rsp_out_day,
   output logic      [pdd_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                              rsp_last
);
   import pdd_pkg::*;

   localparam int CNT_W = $clog2(MAX_RUN + 1);

   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [CNT_W-1:0]   slot_ff,  slot_in;

   logic [CODE_W-1:0]  code_ff;
   logic [YEAR_W-1:0]  oyear_ff;
   logic [MONTH_W-1:0] omonth_ff;
   logic [DAY_W-1:0]   oday_ff;
   logic [CNT_W-1:0]   oslot_ff;
   logic               olast_ff;

   logic [RUN_W-1:0]   run_sat;
   logic [YEAR_W-1:0]  prev_year;
   logic [MONTH_W-1:0] prev_month;
   logic [CODE_W-1:0]  code_now;

   // Clamp the run length to the slot capacity
   assign run_sat = (req_run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : req_run_length;

   assign sts.len_zero  = (req_run_length == '0);
   assign sts.slot_zero = (slot_ff == '0);

   always_comb begin
      prev_year  = year_ff;
      prev_month = month_ff - 4'd1;
      if (month_ff == MONTH_JAN) begin
         prev_month = MONTH_DEC;
         prev_year  = (year_ff == '0) ? YEAR_TOP : year_ff - 7'd1;
      end
   end

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      slot_in  = slot_ff;
      if (cmd.load) begin
         year_in  = (req_start_year >= YEAR_SPAN) ? req_start_year - YEAR_SPAN
                                                  : req_start_year;
         month_in = (req_start_month == '0)      ? MONTH_JAN :
                    (req_start_month > MONTH_DEC) ? MONTH_DEC : req_start_month;
         day_in   = (req_start_day == '0) ? DAY_FIRST : req_start_day;
         slot_in  = CNT_W'(run_sat - 7'd1);
      end else if (cmd.step) begin
         slot_in = slot_ff - CNT_W'(1);
         if (day_ff == DAY_FIRST) begin
            year_in  = prev_year;
            month_in = prev_month;
            day_in   = month_len(prev_year, prev_month);
         end else begin
            day_in = day_ff - 5'd1;
         end
      end
   end

   assign code_now = CODE_W'(day_ff) + CODE_W'(month_ff) * CODE_W'(100)
                   + CODE_W'(year_ff) * CODE_W'(10000);

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      slot_ff  <= slot_in;
      if (cmd.step) begin
         code_ff   <= code_now;
         oyear_ff  <= year_ff;
         omonth_ff <= month_ff;
         oday_ff   <= day_ff;
         oslot_ff  <= slot_ff;
         olast_ff  <= (slot_ff == '0);
      end
   end

   assign rsp_date_code  = code_ff;
   assign rsp_out_year   = oyear_ff;
   assign rsp_out_month  = omonth_ff;
   assign rsp_out_day    = oday_ff;
   assign rsp_slot_index = SLOT_W'(oslot_ff);
   assign rsp_last       = olast_ff;

endmodule

`default_nettype wire

>>> rtl/core/previous_days_date_run.sv
// Channel   | Ports                                   | Beat taken when
// ----------+-----------------------------------------+----------------------------
// request   | start, busy, req_start_year/month/day,  | start high and busy low
//           | req_run_length                          |
// response  | rsp_strobe, rsp_date_code, rsp_out_*,   | every cycle rsp_strobe high
//           | rsp_slot_index, rsp_last                |
//
// A request of length N, clamped to MAX_RUN, gives N response beats on
// consecutive cycles, registered after the load and each run-state step;
// one pass of the shared date step register set per cycle sets the pace.
// Busy drops in the cycle of the last beat; a new request may be taken there.
// A request of length zero gives no beats and busy never rises.
// Reset is synchronous and clears the controller and the response strobe.
// The response side cannot stall: each beat is valid for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module previous_days_date_run #(
   parameter int MAX_RUN = pdd_pkg::MAX_RUN_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [pdd_pkg::YEAR_W-1:0]   req_start_year,
   input  wire logic [pdd_pkg::MONTH_W-1:0]  req_start_month,
   input  wire logic [pdd_pkg::DAY_W-1:0]    req_start_day,
   input  wire logic [pdd_pkg::RUN_W-1:0]    req_run_length,
   output logic                              rsp_strobe,
   output logic      [pdd_pkg::CODE_W-1:0]   rsp_date_code,
   output logic      [pdd_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic      [pdd_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic      [pdd_pkg::DAY_W-1:0]    rsp_out_day,
   output logic      [pdd_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                              rsp_last
);
   import pdd_pkg::*;

   pdd_cmd_type cmd;
   pdd_sts_type sts;

   // Sequence the run: load on the request beat, then advance one day a cycle
   pdd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   // Hold the current date and slot count; register each emitted date
   pdd_dpath #(
      .MAX_RUN (MAX_RUN)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_run_length  (req_run_length),
      .rsp_date_code   (rsp_date_code),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_last        (rsp_last)
   );

   // Drop the strobe right after the final beat of a run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("response beat after the last beat of a run");

   // A zero-length request never raises busy
   a_zero_len_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_run_length == '0)) |=> !busy)
      else $error("busy raised for a zero-length request");

   // Each beat comes out of a running sequence
   a_beat_from_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response beat without an active run");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pdd_pkg::*;

   localparam int RUN_CAP        = MAX_RUN_DEF;
   localparam int RANDOM_BEATS   = 350;
   localparam int CALM_TAIL      = 50;    // last random beats go out back to back
   localparam int DRAIN_CYCLES   = 8;     // wait for stray beats after the last owed date
   localparam int WATCHDOG_LIMIT = 500;   // well above the longest hold_off gap
   localparam int REPORT_MAX     = 10;

   // One emitted date, in the order of the response ports.
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [SLOT_W-1:0]  slot;
      logic               last;
   } date_beat_type;

   // One directed request; typed rows carry the first and final date code.
   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [RUN_W-1:0]   length;
      bit                 typed;
      logic [CODE_W-1:0]  code_first;
      logic [CODE_W-1:0]  code_final;
   } plan_row_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic [YEAR_W-1:0]  req_start_year  = '0;
   logic [MONTH_W-1:0] req_start_month = '0;
   logic [DAY_W-1:0]   req_start_day   = '0;
   logic [RUN_W-1:0]   req_run_length  = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [CODE_W-1:0]  rsp_date_code;
   logic [YEAR_W-1:0]  rsp_out_year;
   logic [MONTH_W-1:0] rsp_out_month;
   logic [DAY_W-1:0]   rsp_out_day;
   logic [SLOT_W-1:0]  rsp_slot_index;
   logic               rsp_last;

   date_beat_type pending_dates[$];   // dates still owed by the block, oldest first
   date_beat_type fresh_run[$];       // dates of the request just taken
   plan_row_type  directed_plan[$];
   int            fault_count  = 0;
   int            stall_cycles = 0;

   previous_days_date_run dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_run_length  (req_run_length),
      .rsp_strobe      (rsp_strobe),
      .rsp_date_code   (rsp_date_code),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Length of a month; every fourth two-digit year has a long February.
   function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] year,
                                                input logic [MONTH_W-1:0] month);
      case (month)
         MONTH_FEB: days_in = (year % 4 == 0) ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days_in = 5'd30;
         default: days_in = 5'd31;
      endcase
   endfunction

   // Walk back from the start date and fill fresh_run with the dates owed.
   function automatic void walk_back_dates(input logic [YEAR_W-1:0]  year_in,
                                           input logic [MONTH_W-1:0] month_in,
                                           input logic [DAY_W-1:0]   day_in,
                                           input logic [RUN_W-1:0]   length_in);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      int                 count;
      date_beat_type      beat;
      fresh_run.delete();
      // Clamp the fields the way the block does before walking.
      y     = year_in % YEAR_SPAN;
      m     = (month_in == 0) ? MONTH_JAN : (month_in > MONTH_DEC) ? MONTH_DEC : month_in;
      d     = (day_in == 0) ? DAY_FIRST : day_in;
      count = (length_in > RUN_CAP) ? RUN_CAP : int'(length_in);
      for (int k = 0; k < count; k++) begin
         beat.code  = {15'd0, d} + {16'd0, m} * 20'd100 + {13'd0, y} * 20'd10000;
         beat.year  = y;
         beat.month = m;
         beat.day   = d;
         beat.slot  = SLOT_W'(count - 1 - k);
         beat.last  = (k == count - 1);
         fresh_run.push_back(beat);
         // Day one steps to the last day of the month before, January to December.
         if (d == DAY_FIRST) begin
            if (m == MONTH_JAN) begin
               m = MONTH_DEC;
               y = (y == 0) ? YEAR_TOP : y - 7'd1;
            end else begin
               m = m - 4'd1;
            end
            d = days_in(y, m);
         end else begin
            d = d - 5'd1;
         end
      end
   endfunction

   function automatic void add_row(input int year, input int month, input int day,
                                   input int length, input bit typed,
                                   input int code_first, input int code_final);
      plan_row_type row;
      row.year       = YEAR_W'(year);
      row.month      = MONTH_W'(month);
      row.day        = DAY_W'(day);
      row.length     = RUN_W'(length);
      row.typed      = typed;
      row.code_first = CODE_W'(code_first);
      row.code_final = CODE_W'(code_final);
      directed_plan.push_back(row);
   endfunction

   task automatic note_fault(input string msg);
      if (fault_count < REPORT_MAX) begin
         $display("%0t ns: %s", $realtime, msg);
      end
      fault_count++;
   endtask

   // Put a request on the ports and hold start until the block takes the beat,
   // then queue the dates it owes. Typed rows override the first and final code.
   task automatic send_request(input plan_row_type row);
      start           <= 1'b1;
      req_start_year  <= row.year;
      req_start_month <= row.month;
      req_start_day   <= row.day;
      req_run_length  <= row.length;
      do @(posedge clock); while (busy);
      walk_back_dates(row.year, row.month, row.day, row.length);
      if (row.typed && fresh_run.size() > 0) begin
         fresh_run[0].code                    = row.code_first;
         fresh_run[fresh_run.size() - 1].code = row.code_final;
      end
      foreach (fresh_run[i]) pending_dates.push_back(fresh_run[i]);
   endtask

   // Drop start for a burst and wiggle the request fields meanwhile.
   task automatic hold_off(input int cycles);
      start           <= 1'b0;
      req_start_year  <= YEAR_W'($urandom);
      req_start_month <= MONTH_W'($urandom);
      req_start_day   <= DAY_W'($urandom);
      req_run_length  <= RUN_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   function automatic plan_row_type random_request();
      plan_row_type row;
      int           kind;
      int           pick;
      kind      = $urandom_range(0, 9);
      row.typed = 1'b0;
      // Mostly well-formed dates; a few out-of-range fields for the clamps.
      row.year  = (kind == 0) ? YEAR_W'($urandom_range(0, 127))
                              : YEAR_W'($urandom_range(0, 99));
      row.month = (kind == 1) ? MONTH_W'($urandom_range(0, 15))
                              : MONTH_W'($urandom_range(1, 12));
      // Favor early days so runs cross month and year boundaries.
      if (kind == 2) begin
         row.day = DAY_W'($urandom_range(0, 31));
      end else if ($urandom_range(0, 1) == 0) begin
         row.day = DAY_W'($urandom_range(1, 3));
      end else begin
         row.day = DAY_W'($urandom_range(1, days_in(row.year % YEAR_SPAN, row.month)));
      end
      pick = $urandom_range(0, 19);
      case (pick)
         0:       row.length = '0;
         1:       row.length = RUN_W'($urandom_range(RUN_CAP + 1, 127));
         2:       row.length = RUN_W'(RUN_CAP);
         default: row.length = RUN_W'($urandom_range(1, 40));
      endcase
      row.code_first = '0;
      row.code_final = '0;
      return row;
   endfunction

   // Response checker: the block cannot be stalled, so take every strobe.
   always @(posedge clock) begin
      date_beat_type got;
      date_beat_type want;
      string         msg;
      if (!reset && rsp_strobe) begin
         got = '{rsp_date_code, rsp_out_year, rsp_out_month, rsp_out_day,
                 rsp_slot_index, rsp_last};
         if (pending_dates.size() == 0) begin
            note_fault($sformatf("unexpected date beat, code %0d", got.code));
         end else begin
            want = pending_dates.pop_front();
            if (got != want) begin
               msg = $sformatf("date mismatch: exp %0d %0d/%0d/%0d slot %0d last %0b",
                               want.code, want.year, want.month, want.day, want.slot, want.last);
               msg = {msg, $sformatf(", got %0d %0d/%0d/%0d slot %0d last %0b",
                                     got.code, got.year, got.month, got.day, got.slot, got.last)};
               note_fault(msg);
            end
         end
      end
   end

   // Watchdog: give up once nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // Calendar edges first: year wrap, leap Februaries, each short month,
      // empty runs, clamped fields, a start day past month end, longest runs.
      add_row(0,   1,  1,  2,   1, 101,    991231);
      add_row(99,  12, 31, 1,   1, 991231, 991231);
      add_row(0,   3,  1,  2,   1, 301,    229);
      add_row(1,   3,  1,  2,   1, 10301,  10228);
      add_row(4,   3,  1,  2,   1, 40301,  40229);
      add_row(5,   5,  5,  0,   1, 0,      0);
      add_row(5,   5,  5,  0,   1, 0,      0);
      add_row(127, 15, 31, 127, 0, 0,      0);
      add_row(100, 0,  0,  1,   1, 101,    101);
      add_row(50,  2,  31, 3,   1, 500231, 500229);
      add_row(13,  13, 0,  1,   1, 131201, 131201);
      add_row(30,  4,  1,  2,   1, 300401, 300331);
      add_row(31,  5,  1,  2,   1, 310501, 310430);
      add_row(32,  7,  1,  2,   1, 320701, 320630);
      add_row(33,  10, 1,  2,   1, 331001, 330930);
      add_row(34,  12, 1,  2,   1, 341201, 341130);
      add_row(20,  1,  1,  64,  0, 0,      0);
      add_row(21,  6,  15, 65,  0, 0,      0);
      add_row(96,  2,  29, 1,   1, 960229, 960229);
      add_row(97,  2,  28, 1,   1, 970228, 970228);
      add_row(0,   1,  31, 40,  0, 0,      0);
      add_row(99,  11, 30, 0,   1, 0,      0);
      add_row(64,  8,  16, 63,  0, 0,      0);

      // Hold reset, then release it.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         send_request(directed_plan[i]);
         if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 11));
      end

      // Random part; leave the tail free of gaps.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         send_request(random_request());
         if (i < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 2) == 0) begin
            hold_off($urandom_range(1, 11));
         end
      end
      start <= 1'b0;

      // Drain: wait for every owed date, then DRAIN_CYCLES more for stray beats.
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_dates.size() != 0) begin
         note_fault($sformatf("%0d dates never arrived", pending_dates.size()));
      end
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/pdd_pkg.sv
rtl/core/pdd_ctrl.sv
rtl/core/pdd_dpath.sv
rtl/core/previous_days_date_run.sv
dv/tb_top.sv
